// ----- src/rmse_pkg.sv -----
// Shared types and constants of the RMS error tracker.
`timescale 1ns / 1ps
package rmse_pkg;

  // Fixed field widths
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned SQ_W    = 32;
  localparam int unsigned RMS_W   = 16;
  localparam int unsigned CONF_W  = 13;
  localparam int unsigned SMTH_W  = 16;
  localparam int unsigned EMA_W   = 20;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 48;
  localparam int unsigned M_PAD_W  = M_DATA_W - RMS_W - CONF_W - SMTH_W;

  // Queue between front and back
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QLVL_W      = 3;

  // Arithmetic constants
  localparam logic [RMS_W-1:0]  RMS_MAX = 16'hFFFF;
  localparam logic [CONF_W-1:0] ONE_Q12 = 13'd4096;
  // Divide by ten as multiply by ceil(2^23 / 10), exact for numerators below 2^22
  localparam logic [EMA_W-1:0]  EMA_RECIP = 20'd838861;
  localparam int unsigned       EMA_SHIFT = 23;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_CLEAR  = 1'b1
  } cmd_e;

  typedef enum logic [4:0] {
    ST_IDLE     = 5'b00001,
    ST_DIV_MEAN = 5'b00010,
    ST_SQRT     = 5'b00100,
    ST_DIV_EMA  = 5'b01000,
    ST_OUT      = 5'b10000
  } back_state_e;

endpackage

// ----- src/rmse_div.sv -----
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module rmse_div #(
  parameter int unsigned N = 42,
  parameter int unsigned D = 13
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [N-1:0] dividend_i,
  input  logic [D-1:0] divisor_i,
  output logic         done_o,
  output logic [N-1:0] quotient_o
);

  localparam int unsigned CW = $clog2(N + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [N-1:0]  quo_q, quo_d;
  logic [D-1:0]  rem_q, rem_d;
  logic [D-1:0]  dvs_q, dvs_d;
  logic [D:0]    shifted;
  logic [D:0]    diff;
  logic          fits;

  assign shifted = {rem_q, quo_q[N-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign fits    = shifted >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(N);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? diff[D-1:0] : shifted[D-1:0];
      quo_d = {quo_q[N-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- src/rmse_front.sv -----
// Front: accept pairs, square differences, accumulate, push vector ends and clears.
`timescale 1ns / 1ps
module rmse_front #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned CNT_W = 11,
  parameter int unsigned SUM_W = 42,
  parameter int unsigned ENT_W = 54
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  rmse_pkg::cmd_e             cmd_i,
  input  logic [rmse_pkg::VAL_W-1:0] pred_i,
  input  logic [rmse_pkg::VAL_W-1:0] act_i,
  input  logic                       last_i,
  input  logic [rmse_pkg::QLVL_W-1:0] q_free_i,
  output logic                       push_o,
  output logic [ENT_W-1:0]           push_data_o
);

  import rmse_pkg::*;

  logic               accept;
  logic               acc_ok;
  logic [CNT_W-1:0]   cnt_q, cnt_d, cnt_inc;
  logic signed [VAL_W:0] diff;
  logic [MAG_W-1:0]   mag;

  // stage 1: magnitude
  logic               s1_vld_q;
  cmd_e               s1_cmd_q;
  logic               s1_tok_q, s1_acc_q;
  logic [MAG_W-1:0]   s1_mag_q;
  logic [CNT_W-1:0]   s1_cnt_q;
  // stage 2: square
  logic               s2_vld_q;
  cmd_e               s2_cmd_q;
  logic               s2_tok_q, s2_acc_q;
  logic [SQ_W-1:0]    s2_sq_q;
  logic [CNT_W-1:0]   s2_cnt_q;
  // accumulator
  logic [SUM_W-1:0]   sum_q, sum_d, sum_add;
  logic [1:0]         inflight;

  assign inflight = {1'b0, s1_vld_q & s1_tok_q} + {1'b0, s2_vld_q & s2_tok_q};
  assign ready_o  = q_free_i > QLVL_W'(inflight);
  assign accept   = valid_i & ready_o;

  assign acc_ok  = cnt_q < CNT_W'(MAX_ELEMENTS);
  assign cnt_inc = acc_ok ? cnt_q + 1'b1 : cnt_q;
  assign diff    = $signed({pred_i[VAL_W-1], pred_i}) - $signed({act_i[VAL_W-1], act_i});
  assign mag     = diff[VAL_W] ? MAG_W'(-diff) : MAG_W'(diff);

  always_comb begin
    cnt_d = cnt_q;
    if (accept && cmd_i == CMD_SAMPLE) begin
      cnt_d = last_i ? '0 : cnt_inc;
    end
  end

  assign sum_add = sum_q + (s2_acc_q ? SUM_W'(s2_sq_q) : '0);

  always_comb begin
    sum_d = sum_q;
    if (s2_vld_q && s2_cmd_q == CMD_SAMPLE) begin
      sum_d = s2_tok_q ? '0 : sum_add;
    end
  end

  assign push_o      = s2_vld_q & s2_tok_q;
  assign push_data_o = {s2_cmd_q, s2_cnt_q, sum_add};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q <= cmd_i;
    s1_tok_q <= (cmd_i == CMD_CLEAR) | last_i;
    s1_acc_q <= (cmd_i == CMD_SAMPLE) & acc_ok;
    s1_mag_q <= mag;
    s1_cnt_q <= cnt_inc;
    s2_cmd_q <= s1_cmd_q;
    s2_tok_q <= s1_tok_q;
    s2_acc_q <= s1_acc_q;
    s2_sq_q  <= s1_mag_q * s1_mag_q;
    s2_cnt_q <= s1_cnt_q;
  end

endmodule

// ----- src/rmse_queue.sv -----
// Short queue of vector-end and clear transactions between front and back.
`timescale 1ns / 1ps
module rmse_queue #(
  parameter int unsigned ENT_W = 54
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  logic [ENT_W-1:0]            push_data_i,
  input  logic                        pop_i,
  output logic                        empty_o,
  output logic [ENT_W-1:0]            head_o,
  output logic [rmse_pkg::QLVL_W-1:0] free_o
);

  import rmse_pkg::*;

  logic [ENT_W-1:0]  mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QLVL_W-1:0] lvl_q;

  assign empty_o = lvl_q == '0;
  assign head_o  = mem_q[rd_q];
  assign free_o  = QLVL_W'(QUEUE_DEPTH) - lvl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      lvl_q <= lvl_q + QLVL_W'(push_i) - QLVL_W'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

endmodule

// ----- src/rmse_back.sv -----
// Back: mean by division, square root, smoothing, output register.
`timescale 1ns / 1ps
module rmse_back #(
  parameter int unsigned CNT_W = 11,
  parameter int unsigned SUM_W = 42,
  parameter int unsigned ENT_W = 54
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  logic [ENT_W-1:0]            q_head_i,
  output logic                        q_pop_o,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output logic [rmse_pkg::RMS_W-1:0]  rms_o,
  output logic [rmse_pkg::CONF_W-1:0] conf_o,
  output logic [rmse_pkg::SMTH_W-1:0] smooth_o
);

  import rmse_pkg::*;

  localparam int unsigned RAD_W  = SUM_W + (SUM_W % 2);
  localparam int unsigned RT_W   = RAD_W / 2;
  localparam int unsigned SQC_W  = $clog2(RT_W + 1);

  back_state_e state_q, state_d;

  cmd_e              head_cmd;
  logic [CNT_W-1:0]  head_cnt;
  logic [SUM_W-1:0]  head_sum;

  logic              div_start, div_done;
  logic [SUM_W-1:0]  div_quo;

  logic              zero_q, zero_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [RT_W:0]     rem_q, rem_d;
  logic [RT_W-1:0]   root_q, root_d;
  logic [SQC_W-1:0]  sqc_q, sqc_d;
  logic [RT_W+2:0]   rem2, trial;

  logic [RMS_W-1:0]  rms_sat;
  logic [RMS_W-1:0]  rms_q, rms_d;
  logic [CONF_W-1:0] conf_q, conf_d;
  logic [SMTH_W-1:0] smth_q, smth_d;
  logic [EMA_W-1:0]  ema_num;
  logic [EMA_W-1:0]  ema_q, ema_d;
  logic [2*EMA_W-1:0] ema_prod;

  logic              avg_vld_q, avg_vld_d;
  logic [SMTH_W-1:0] avg_q, avg_d;
  logic              m_vld_q, m_vld_d;
  logic              m_load;
  logic [RMS_W-1:0]  m_rms_q;
  logic [CONF_W-1:0] m_conf_q;
  logic [SMTH_W-1:0] m_smth_q;

  assign head_cmd = cmd_e'(q_head_i[ENT_W-1]);
  assign head_cnt = q_head_i[SUM_W+CNT_W-1:SUM_W];
  assign head_sum = q_head_i[SUM_W-1:0];

  rmse_div #(
    .N(SUM_W),
    .D(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (head_sum),
    .divisor_i  (head_cnt),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign rem2     = {rem_q, rad_q[RAD_W-1:RAD_W-2]};
  assign trial    = (RT_W+3)'({root_q, 2'b01});
  assign rms_sat  = (root_q > RT_W'(RMS_MAX)) ? RMS_MAX : root_q[RMS_W-1:0];
  assign ema_num  = EMA_W'({avg_q, 3'b000}) + EMA_W'(avg_q) + EMA_W'(rms_sat);
  assign ema_prod = ema_q * EMA_RECIP;
  assign m_load   = !m_vld_q || m_ready_i;

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    zero_d    = zero_q;
    rad_d     = rad_q;
    rem_d     = rem_q;
    root_d    = root_q;
    sqc_d     = sqc_q;
    rms_d     = rms_q;
    conf_d    = conf_q;
    smth_d    = smth_q;
    ema_d     = ema_q;
    avg_vld_d = avg_vld_q;
    avg_d     = avg_q;
    m_vld_d   = m_vld_q & ~m_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (head_cmd == CMD_CLEAR) begin
            avg_vld_d = 1'b0;
          end else begin
            div_start = 1'b1;
            zero_d    = head_cnt == '0;
            state_d   = ST_DIV_MEAN;
          end
        end
      end
      ST_DIV_MEAN: begin
        if (div_done) begin
          rad_d   = zero_q ? '0 : RAD_W'(div_quo);
          rem_d   = '0;
          root_d  = '0;
          sqc_d   = SQC_W'(RT_W);
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sqc_q != '0) begin
          rad_d = {rad_q[RAD_W-3:0], 2'b00};
          sqc_d = sqc_q - 1'b1;
          if (rem2 >= trial) begin
            rem_d  = (RT_W+1)'(rem2 - trial);
            root_d = {root_q[RT_W-2:0], 1'b1};
          end else begin
            rem_d  = rem2[RT_W:0];
            root_d = {root_q[RT_W-2:0], 1'b0};
          end
        end else begin
          rms_d  = rms_sat;
          conf_d = (rms_sat >= RMS_W'(ONE_Q12)) ? '0 : ONE_Q12 - CONF_W'(rms_sat);
          if (avg_vld_q) begin
            ema_d   = ema_num;
            state_d = ST_DIV_EMA;
          end else begin
            smth_d  = rms_sat;
            state_d = ST_OUT;
          end
        end
      end
      ST_DIV_EMA: begin
        smth_d  = ema_prod[EMA_SHIFT +: SMTH_W];
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (m_load) begin
          m_vld_d   = 1'b1;
          avg_d     = smth_q;
          avg_vld_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      avg_vld_q <= 1'b0;
      avg_q     <= '0;
      m_vld_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      avg_vld_q <= avg_vld_d;
      avg_q     <= avg_d;
      m_vld_q   <= m_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    sqc_q  <= sqc_d;
    rms_q  <= rms_d;
    conf_q <= conf_d;
    smth_q <= smth_d;
    ema_q  <= ema_d;
    if (state_q == ST_OUT && m_load) begin
      m_rms_q  <= rms_q;
      m_conf_q <= conf_q;
      m_smth_q <= smth_q;
    end
  end

  assign m_valid_o = m_vld_q;
  assign rms_o     = m_rms_q;
  assign conf_o    = m_conf_q;
  assign smooth_o  = m_smth_q;

endmodule

// ----- src/rms_error_ema_tracker_core.sv -----
// Top level of the RMS error tracker with exponential moving average.
//
//  channel  dir  tdata                                   tuser     tlast
//  s_axis   in   predicted[15:0], actual[31:16]          command   last_element
//  m_axis   out  rms[15:0], confidence[28:16],           -         -
//                smoothed[44:29], zero pad[47:45]
//
// Element pairs are taken one per cycle while s_axis_tready is high; the
// front squares each difference over two register stages and adds it into
// the running sum. For each vector end the back runs the serial divider
// for the mean, the two-bit-per-step square root, and, when there is
// smoothing history, a reciprocal multiply for the divide by ten. A clear
// only drops the smoothing history in the back.
// A four-entry queue holds pending vector ends and clears; s_axis_tready
// drops only when the queue could not take the transactions in flight.
// Reset is asynchronous, active low, and returns all sums and smoothing
// state to zero.
`timescale 1ns / 1ps
module rms_error_ema_tracker_core #(
  parameter int unsigned MAX_ELEMENTS = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rmse_pkg::S_DATA_W-1:0] s_axis_tdata,  // predicted_value, actual_value
  input  logic                          s_axis_tuser,  // command
  input  logic                          s_axis_tlast,  // last_element
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [rmse_pkg::M_DATA_W-1:0] m_axis_tdata   // rms, confidence, smoothed, pad
);

  import rmse_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned SUM_W = SQ_W + $clog2(MAX_ELEMENTS);
  localparam int unsigned ENT_W = 1 + CNT_W + SUM_W;

  logic              push, pop, q_empty;
  logic [ENT_W-1:0]  push_data, q_head;
  logic [QLVL_W-1:0] q_free;
  logic [RMS_W-1:0]  rms;
  logic [CONF_W-1:0] conf;
  logic [SMTH_W-1:0] smooth;

  // Front: take every transaction, fold samples into the running sum.
  rmse_front #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .CNT_W       (CNT_W),
    .SUM_W       (SUM_W),
    .ENT_W       (ENT_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s_axis_tvalid),
    .ready_o     (s_axis_tready),
    .cmd_i       (cmd_e'(s_axis_tuser)),
    .pred_i      (s_axis_tdata[VAL_W-1:0]),
    .act_i       (s_axis_tdata[2*VAL_W-1:VAL_W]),
    .last_i      (s_axis_tlast),
    .q_free_i    (q_free),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // Queue: hold vector ends and clears in order.
  rmse_queue #(
    .ENT_W(ENT_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .empty_o     (q_empty),
    .head_o      (q_head),
    .free_o      (q_free)
  );

  // Back: divide, take the root, smooth, and present the result.
  rmse_back #(
    .CNT_W(CNT_W),
    .SUM_W(SUM_W),
    .ENT_W(ENT_W)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (q_head),
    .q_pop_o   (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .rms_o     (rms),
    .conf_o    (conf),
    .smooth_o  (smooth)
  );

  assign m_axis_tdata = {{M_PAD_W{1'b0}}, smooth, conf, rms};

endmodule

// ----- dv/rms_error_ema_tracker_core_tb.sv -----
// Self-checking testbench for the RMS error tracker with moving average.
`timescale 1ns / 1ps
module rms_error_ema_tracker_core_tb;
  import rmse_pkg::*;

  localparam int unsigned MAX_ELEMS    = 1024;
  localparam int unsigned RANDOM_ITEMS = 850;
  localparam int unsigned CALM_ITEMS   = 120;
  localparam int unsigned QUIET_LIMIT  = 4000;
  localparam int unsigned TAIL_CYCLES  = 300;

  typedef struct packed {
    logic [RMS_W-1:0]  rms;
    logic [CONF_W-1:0] conf;
    logic [SMTH_W-1:0] smooth;
  } err_report_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [VAL_W-1:0]  pred;
    logic [VAL_W-1:0]  act;
    logic              last;
    logic              typed;
    err_report_t       report;
  } stim_row_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  s_axis_tlast = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0]   m_axis_tdata;

  rms_error_ema_tracker_core #(
    .MAX_ELEMENTS(MAX_ELEMS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Tracker state mirrored by the predictor
  logic [63:0]       err_square_sum = '0;
  int unsigned       err_elem_count = 0;
  logic [SMTH_W-1:0] ema_value = '0;
  bit                ema_valid = 1'b0;

  err_report_t pending_reports[$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles = 0;
  bit          calm = 1'b0;

  function automatic logic [63:0] floor_root(input logic [63:0] n);
    logic [63:0] rem  = n;
    logic [63:0] root = '0;
    logic [63:0] step = 64'h4000_0000_0000_0000;
    while (step > rem) step >>= 2;
    while (step != 0) begin
      if (rem >= root + step) begin
        rem  = rem - (root + step);
        root = (root >> 1) + step;
      end else begin
        root >>= 1;
      end
      step >>= 2;
    end
    return root;
  endfunction

  // Advance the mirrored state by one transaction; return 1 when a report is due.
  function automatic bit track_element(input cmd_e cmd, input logic [VAL_W-1:0] pred,
                                       input logic [VAL_W-1:0] act, input logic last,
                                       output err_report_t rep);
    int          diff;
    longint unsigned mag;
    logic [63:0] mean;
    logic [63:0] root;
    int unsigned rms;
    int unsigned smooth;
    rep = '0;
    if (cmd == CMD_CLEAR) begin
      ema_valid = 1'b0;
      return 1'b0;
    end
    if (err_elem_count < MAX_ELEMS) begin
      diff = int'($signed(pred)) - int'($signed(act));
      mag  = (diff < 0) ? -diff : diff;
      err_square_sum += mag * mag;
      err_elem_count++;
    end
    if (!last) return 1'b0;
    mean = (err_elem_count != 0) ? err_square_sum / err_elem_count : '0;
    root = floor_root(mean);
    rms  = (root > 64'd65535) ? 65535 : int'(root[31:0]);
    smooth = ema_valid ? (9 * ema_value + rms) / 10 : rms;
    rep.rms    = rms[RMS_W-1:0];
    rep.conf   = (rms >= 4096) ? '0 : CONF_W'(4096 - rms);
    rep.smooth = smooth[SMTH_W-1:0];
    ema_value      = smooth[SMTH_W-1:0];
    ema_valid      = 1'b1;
    err_square_sum = '0;
    err_elem_count = 0;
    return 1'b1;
  endfunction

  // Offer one transaction, wait for the handshake, then queue what it should produce.
  task automatic push_item(input cmd_e cmd, input logic [VAL_W-1:0] pred,
                           input logic [VAL_W-1:0] act, input logic last,
                           input logic typed, input err_report_t typed_rep);
    err_report_t rep;
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {act, pred};
    s_axis_tuser  <= cmd;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (track_element(cmd, pred, act, last, rep)) begin
      if (typed) rep = typed_rep;
      pending_reports = {pending_reports, rep};
    end
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 6))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3, 4:    return VAL_W'($urandom_range(0, 8191) - 4096);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Receiver back-pressure: occasional bursts of stall, none once calm
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 9) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Result checker and watchdog
  always @(posedge clk_i) begin
    err_report_t seen;
    err_report_t want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen.rms    = m_axis_tdata[RMS_W-1:0];
        seen.conf   = m_axis_tdata[RMS_W +: CONF_W];
        seen.smooth = m_axis_tdata[RMS_W+CONF_W +: SMTH_W];
        if (pending_reports.size() == 0) begin
          $error("unexpected result: rms=%0d confidence=%0d smoothed=%0d",
                 seen.rms, seen.conf, seen.smooth);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          if (seen.rms !== want.rms) begin
            $error("rms_error: expected %0d, actual %0d", want.rms, seen.rms);
            mismatch_count++;
          end
          if (seen.conf !== want.conf) begin
            $error("confidence_level: expected %0d, actual %0d", want.conf, seen.conf);
            mismatch_count++;
          end
          if (seen.smooth !== want.smooth) begin
            $error("smoothed_error: expected %0d, actual %0d", want.smooth, seen.smooth);
            mismatch_count++;
          end
        end
      end
    end
  end

  stim_row_t directed_rows[] = '{
    // first vector after reset: no smoothing history
    '{CMD_SAMPLE, 16'h0000, 16'h0000, 1'b1, 1'b1, '{16'd0, 13'd4096, 16'd0}},
    // largest difference, then smoothed against the zero above
    '{CMD_SAMPLE, 16'h7FFF, 16'h8000, 1'b1, 1'b1, '{16'd65535, 13'd0, 16'd6553}},
    // clear ignores its data and mark
    '{CMD_CLEAR,  16'h7FFF, 16'h8000, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 16'h8000, 16'h7FFF, 1'b1, 1'b1, '{16'd65535, 13'd0, 16'd65535}},
    '{CMD_SAMPLE, 16'h1000, 16'h0000, 1'b1, 1'b1, '{16'd4096, 13'd0, 16'd59391}},
    '{CMD_SAMPLE, 16'h0000, 16'h0FFF, 1'b1, 1'b1, '{16'd4095, 13'd1, 16'd53861}},
    '{CMD_SAMPLE, 16'h0003, 16'h0000, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 16'h0000, 16'h0004, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 16'h0000, 16'h0000, 1'b1, 1'b0, '0},
    // clear in the middle of a vector keeps the partial sum
    '{CMD_SAMPLE, 16'h0100, 16'h0000, 1'b0, 1'b0, '0},
    '{CMD_CLEAR,  16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 16'h0000, 16'h0100, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 16'h8000, 16'h8000, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 16'hFFFF, 16'h0001, 1'b1, 1'b0, '0},
    '{CMD_CLEAR,  16'h0000, 16'h0000, 1'b0, 1'b0, '0},
    '{CMD_CLEAR,  16'h1234, 16'h5678, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 16'h5555, 16'hAAAA, 1'b0, 1'b0, '0},
    '{CMD_SAMPLE, 16'hAAAA, 16'h5555, 1'b1, 1'b0, '0},
    '{CMD_SAMPLE, 16'h0001, 16'h0000, 1'b1, 1'b0, '0}
  };

  initial begin
    int unsigned sent;
    int unsigned vec_len;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      push_item(directed_rows[i].cmd, directed_rows[i].pred, directed_rows[i].act,
                directed_rows[i].last, directed_rows[i].typed, directed_rows[i].report);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      calm = (sent + CALM_ITEMS >= RANDOM_ITEMS);
      case ($urandom_range(0, 19))
        0:           vec_len = $urandom_range(25, 80);
        1, 2, 3, 4:  vec_len = $urandom_range(5, 24);
        default:     vec_len = $urandom_range(1, 4);
      endcase
      for (int unsigned k = 0; k < vec_len; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          push_item(CMD_CLEAR, VAL_W'($urandom), VAL_W'($urandom), 1'($urandom),
                    1'b0, '0);
          sent++;
        end
        push_item(CMD_SAMPLE, pick_value(), pick_value(), k == vec_len - 1, 1'b0, '0);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
